FILE: design/calendar_date_add_weekday_macros.svh
// Assertion macros shared by the calendar date block.
`ifndef CALENDAR_DATE_ADD_WEEKDAY_MACROS_SVH
`define CALENDAR_DATE_ADD_WEEKDAY_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define CDAW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date assertion failed");

// Next-cycle implication.
`define CDAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date assertion failed");

`else

`define CDAW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CDAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/cdaw_pkg.sv
// Types, constants and calendar helper functions for the calendar date block.
package cdaw_pkg;

    localparam int DIV_W  = 17;   // dividend and quotient width of the shared divider
    localparam int DIVR_W = 7;    // divisor and remainder width

    localparam logic [DIVR_W-1:0] DIV_MONTHS  = 7'd12;
    localparam logic [DIVR_W-1:0] DIV_CENTURY = 7'd100;

    // ceil(2^23 / d): exact for any 17-bit dividend by 12 and any 16-bit year by 100
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP_MONTHS  = 20'd699051;
    localparam logic [RECIP_W-1:0] RECIP_CENTURY = 20'd83887;

    localparam logic [15:0] YEAR_SPLIT   = 16'd1700;
    localparam logic [7:0]  CENTURY_BASE = 8'd18;
    localparam logic [4:0]  RESET_DAY    = 5'd1;
    localparam logic [3:0]  RESET_MONTH  = 4'd1;
    localparam logic [15:0] RESET_YEAR   = 16'd2000;
    localparam logic [9:0]  RESET_CENT   = 10'd20;
    localparam logic [6:0]  RESET_YY     = 7'd0;

    localparam logic [2:0] CENTURY_TAB [4] = '{3'd4, 3'd2, 3'd0, 3'd6};

    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_ADD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVY,
        ST_WAITY,
        ST_NORM,
        ST_MADD,
        ST_WAITM,
        ST_YADD,
        ST_COMMIT,
        ST_WDAY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVR_W-1:0] remainder;
    } div_rsp_t;

    // Leap test from the year and its split into year/100 and year%100.
    function automatic logic is_leap(input logic [15:0] y, input logic [9:0] cent,
                                     input logic [6:0] yy);
        logic by4;
        by4 = (y[1:0] == 2'd0);
        if (y > YEAR_SPLIT)
            return by4 && ((yy != 7'd0) || (cent[1:0] == 2'd0));
        return by4;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] month_code(input logic [3:0] m);
        logic [2:0] c;
        unique case (m)
            4'd2, 4'd3, 4'd11: c = 3'd3;
            4'd4, 4'd7:        c = 3'd6;
            4'd5:              c = 3'd1;
            4'd6:              c = 3'd4;
            4'd8:              c = 3'd2;
            4'd9, 4'd12:       c = 3'd5;
            default:           c = 3'd0;
        endcase
        return c;
    endfunction

    // Remainder by 7 for values below 224: five conditional subtracts.
    function automatic logic [2:0] mod7(input logic [7:0] v);
        logic [7:0] t;
        t = v;
        if (t >= 8'd112) t = t - 8'd112;
        if (t >= 8'd56)  t = t - 8'd56;
        if (t >= 8'd28)  t = t - 8'd28;
        if (t >= 8'd14)  t = t - 8'd14;
        if (t >= 8'd7)   t = t - 8'd7;
        return t[2:0];
    endfunction

endpackage

FILE: design/cdaw_div.sv
// Divider by a small constant through reciprocal multiplication, one request at a time.
module cdaw_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cdaw_pkg::div_req_t req,
    output cdaw_pkg::div_rsp_t rsp
);

    localparam int PROD_W = cdaw_pkg::DIV_W + cdaw_pkg::RECIP_W;

    logic                         mul_pend_reg, mul_pend_next;
    logic                         fin_pend_reg, fin_pend_next;
    logic                         done_reg, done_next;
    logic [cdaw_pkg::DIV_W-1:0]   num_reg, num_next;
    logic [cdaw_pkg::DIVR_W-1:0]  dsr_reg, dsr_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [cdaw_pkg::DIV_W-1:0]   quo_reg, quo_next;
    logic [cdaw_pkg::DIVR_W-1:0]  rem_reg, rem_next;
    logic [cdaw_pkg::RECIP_W-1:0] recip;
    logic [cdaw_pkg::DIV_W-1:0]   quo;
    logic [cdaw_pkg::DIV_W-1:0]   back;

    // only the month and century divisors are ever requested
    assign recip = (dsr_reg == cdaw_pkg::DIV_MONTHS) ? cdaw_pkg::RECIP_MONTHS
                                                      : cdaw_pkg::RECIP_CENTURY;
    assign quo   = cdaw_pkg::DIV_W'(prod_reg >> cdaw_pkg::RECIP_SHIFT);
    assign back  = cdaw_pkg::DIV_W'(quo * cdaw_pkg::DIV_W'(dsr_reg));

    always_comb
    begin
        mul_pend_next = req.start;
        fin_pend_next = mul_pend_reg;
        done_next     = fin_pend_reg;
        num_next      = num_reg;
        dsr_next      = dsr_reg;
        prod_next     = prod_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        if (req.start)
        begin
            num_next = req.dividend;
            dsr_next = req.divisor;
        end
        if (mul_pend_reg)
        begin
            prod_next = PROD_W'(num_reg) * PROD_W'(recip);
        end
        if (fin_pend_reg)
        begin
            // remainder stays below the divisor
            quo_next = quo;
            rem_next = cdaw_pkg::DIVR_W'(num_reg - back);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            fin_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_pend_reg <= mul_pend_next;
            fin_pend_reg <= fin_pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        dsr_reg  <= dsr_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: design/calendar_date_add_weekday.sv
// Calendar date register with set, add and weekday report: sequencer and datapath.
// The block holds one date (reset: January 1, 2000) and takes one transaction at a
// time; in_ready is high only while the sequencer is idle. A set transaction divides
// the year by 100 in the reciprocal divider to feed the leap test, then checks and
// commits the date. An add transaction rolls the excess days forward month by month,
// adds the months (dividing by 12 when the month sum carries into the year), adds the
// years, splits the new year by 100 and rolls the days again; the month carry and
// the year split share the same divider. One result transaction follows each input
// transaction and waits in the output register; a new input is accepted while it waits,
// and the sequencer then holds in its output state until the register is free.
`include "calendar_date_add_weekday_macros.svh"

module calendar_date_add_weekday (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] day_value,
    input  logic [15:0] month_value,
    input  logic [15:0] year_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [4:0]  cur_day,
    output logic [3:0]  cur_month,
    output logic [15:0] cur_year,
    output logic [2:0]  weekday
);

    cdaw_pkg::state_t   state_reg, state_next;
    cdaw_pkg::div_req_t div_req;
    cdaw_pkg::div_rsp_t div_rsp;

    // stored date and its split into year/100 and year%100
    logic [4:0]  stored_day_reg, stored_day_next;
    logic [3:0]  stored_month_reg, stored_month_next;
    logic [15:0] stored_year_reg, stored_year_next;
    logic [9:0]  stq_reg, stq_next;
    logic [6:0]  str_reg, str_next;

    // working copy
    logic        kind_reg, kind_next;
    logic        pass2_reg, pass2_next;
    logic [16:0] d_reg, d_next;
    logic [16:0] m_reg, m_next;
    logic [15:0] y_reg, y_next;
    logic [9:0]  q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [15:0] mv_reg, mv_next;
    logic [15:0] yv_reg, yv_next;
    logic [12:0] extra_reg, extra_next;

    // weekday partial codes
    logic [2:0]  ycode_reg, ycode_next;
    logic [2:0]  ccode_reg, ccode_next;
    logic        lcode_reg, lcode_next;

    logic        out_valid_reg, out_valid_next;
    logic        acc_reg, acc_next;
    logic        ok_reg, ok_next;
    logic [4:0]  oday_reg, oday_next;
    logic [3:0]  omonth_reg, omonth_next;
    logic [15:0] oyear_reg, oyear_next;
    logic [2:0]  owd_reg, owd_next;

    logic        work_leap;
    logic [4:0]  work_len;
    logic        stored_leap;
    logic [16:0] m_sum;
    logic        set_ok;
    logic [7:0]  wd_sum;

    assign work_leap   = cdaw_pkg::is_leap(y_reg, q_reg, r_reg);
    assign work_len    = cdaw_pkg::month_len(m_reg[3:0], work_leap);
    assign stored_leap = cdaw_pkg::is_leap(stored_year_reg, stq_reg, str_reg);
    assign m_sum       = m_reg + {1'b0, mv_reg};
    assign set_ok      = (m_reg >= 17'd1) && (m_reg <= 17'd12) && (d_reg != 17'd0)
                         && (d_reg <= {12'd0, work_len});
    assign wd_sum      = 8'(ycode_reg) + 8'(cdaw_pkg::month_code(stored_month_reg))
                         + 8'(ccode_reg) + 8'(stored_day_reg) + 8'd7 - 8'(lcode_reg);

    cdaw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        stored_day_next   = stored_day_reg;
        stored_month_next = stored_month_reg;
        stored_year_next  = stored_year_reg;
        stq_next          = stq_reg;
        str_next          = str_reg;
        kind_next         = kind_reg;
        pass2_next        = pass2_reg;
        d_next            = d_reg;
        m_next            = m_reg;
        y_next            = y_reg;
        q_next            = q_reg;
        r_next            = r_reg;
        mv_next           = mv_reg;
        yv_next           = yv_reg;
        extra_next        = extra_reg;
        ycode_next        = ycode_reg;
        ccode_next        = ccode_reg;
        lcode_next        = lcode_reg;
        ok_next           = ok_reg;
        acc_next          = acc_reg;
        oday_next         = oday_reg;
        omonth_next       = omonth_reg;
        oyear_next        = oyear_reg;
        owd_next          = owd_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        div_req.start     = 1'b0;
        div_req.dividend  = {1'b0, y_reg};
        div_req.divisor   = cdaw_pkg::DIV_CENTURY;
        in_ready          = (state_reg == cdaw_pkg::ST_IDLE);

        unique case (state_reg)
            cdaw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    pass2_next = 1'b0;
                    mv_next    = month_value;
                    yv_next    = year_value;
                    q_next     = stq_reg;
                    r_next     = str_reg;
                    if (kind == cdaw_pkg::KIND_ADD)
                    begin
                        d_next     = 17'(stored_day_reg) + {1'b0, day_value};
                        m_next     = 17'(stored_month_reg);
                        y_next     = stored_year_reg;
                        state_next = cdaw_pkg::ST_NORM;
                    end
                    else
                    begin
                        d_next     = {1'b0, day_value};
                        m_next     = {1'b0, month_value};
                        y_next     = year_value;
                        state_next = cdaw_pkg::ST_DIVY;
                    end
                end
            end

            cdaw_pkg::ST_DIVY:
            begin
                div_req.start = 1'b1;
                state_next    = cdaw_pkg::ST_WAITY;
            end

            cdaw_pkg::ST_WAITY:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quotient[9:0];
                    r_next     = div_rsp.remainder;
                    state_next = (kind_reg == cdaw_pkg::KIND_ADD) ? cdaw_pkg::ST_NORM
                                                                  : cdaw_pkg::ST_COMMIT;
                end
            end

            // roll excess days into following months, one month per cycle
            cdaw_pkg::ST_NORM:
            begin
                if (d_reg <= {12'd0, work_len})
                begin
                    state_next = pass2_reg ? cdaw_pkg::ST_COMMIT : cdaw_pkg::ST_MADD;
                end
                else
                begin
                    d_next = d_reg - {12'd0, work_len};
                    if (m_reg == 17'd12)
                    begin
                        m_next = 17'd1;
                        y_next = y_reg + 16'd1;
                        if (y_reg == 16'hFFFF)
                        begin
                            q_next = '0;
                            r_next = '0;
                        end
                        else if (r_reg == 7'd99)
                        begin
                            q_next = q_reg + 10'd1;
                            r_next = '0;
                        end
                        else
                        begin
                            r_next = r_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        m_next = m_reg + 17'd1;
                    end
                end
            end

            cdaw_pkg::ST_MADD:
            begin
                if (m_sum > 17'd12)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = m_sum - 17'd1;
                    div_req.divisor  = cdaw_pkg::DIV_MONTHS;
                    state_next       = cdaw_pkg::ST_WAITM;
                end
                else
                begin
                    m_next     = m_sum;
                    extra_next = '0;
                    state_next = cdaw_pkg::ST_YADD;
                end
            end

            cdaw_pkg::ST_WAITM:
            begin
                if (div_rsp.done)
                begin
                    m_next     = 17'(div_rsp.remainder) + 17'd1;
                    extra_next = div_rsp.quotient[12:0];
                    state_next = cdaw_pkg::ST_YADD;
                end
            end

            cdaw_pkg::ST_YADD:
            begin
                y_next     = 16'(y_reg + 16'(extra_reg) + yv_reg);
                pass2_next = 1'b1;
                state_next = cdaw_pkg::ST_DIVY;
            end

            cdaw_pkg::ST_COMMIT:
            begin
                ok_next = (kind_reg == cdaw_pkg::KIND_ADD) || set_ok;
                if ((kind_reg == cdaw_pkg::KIND_ADD) || set_ok)
                begin
                    stored_day_next   = d_reg[4:0];
                    stored_month_next = m_reg[3:0];
                    stored_year_next  = y_reg;
                    stq_next          = q_reg;
                    str_next          = r_reg;
                end
                state_next = cdaw_pkg::ST_WDAY;
            end

            cdaw_pkg::ST_WDAY:
            begin
                ycode_next = cdaw_pkg::mod7(8'(str_reg) + 8'(str_reg[6:2]));
                // (year-1700)/100 mod 4 equals (year/100 + 3) mod 4 above 1700
                if (stored_year_reg > cdaw_pkg::YEAR_SPLIT)
                    ccode_next = cdaw_pkg::CENTURY_TAB[2'(stq_reg + 10'd3)];
                else
                    ccode_next = cdaw_pkg::mod7(cdaw_pkg::CENTURY_BASE - 8'(stq_reg));
                lcode_next = stored_leap && (stored_month_reg <= 4'd2);
                state_next = cdaw_pkg::ST_OUT;
            end

            cdaw_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = ok_reg;
                    oday_next      = stored_day_reg;
                    omonth_next    = stored_month_reg;
                    oyear_next     = stored_year_reg;
                    owd_next       = cdaw_pkg::mod7(wd_sum);
                    state_next     = cdaw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cdaw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cdaw_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            stored_day_reg   <= cdaw_pkg::RESET_DAY;
            stored_month_reg <= cdaw_pkg::RESET_MONTH;
            stored_year_reg  <= cdaw_pkg::RESET_YEAR;
            stq_reg          <= cdaw_pkg::RESET_CENT;
            str_reg          <= cdaw_pkg::RESET_YY;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            stored_day_reg   <= stored_day_next;
            stored_month_reg <= stored_month_next;
            stored_year_reg  <= stored_year_next;
            stq_reg          <= stq_next;
            str_reg          <= str_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pass2_reg  <= pass2_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        y_reg      <= y_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        mv_reg     <= mv_next;
        yv_reg     <= yv_next;
        extra_reg  <= extra_next;
        ycode_reg  <= ycode_next;
        ccode_reg  <= ccode_next;
        lcode_reg  <= lcode_next;
        ok_reg     <= ok_next;
        acc_reg    <= acc_next;
        oday_reg   <= oday_next;
        omonth_reg <= omonth_next;
        oyear_reg  <= oyear_next;
        owd_reg    <= owd_next;
    end

    assign out_valid = out_valid_reg;
    assign accepted  = acc_reg;
    assign cur_day   = oday_reg;
    assign cur_month = omonth_reg;
    assign cur_year  = oyear_reg;
    assign weekday   = owd_reg;

    `CDAW_ASSERT_IMP(a_month_range, clk, rst_n, 1'b1, (stored_month_reg >= 4'd1) && (stored_month_reg <= 4'd12))
    `CDAW_ASSERT_IMP(a_day_range, clk, rst_n, 1'b1, (stored_day_reg != 5'd0) && (stored_day_reg <= cdaw_pkg::month_len(stored_month_reg, stored_leap)))
    `CDAW_ASSERT_IMP(a_year_split, clk, rst_n, 1'b1, (32'(stq_reg) * 32'd100 + 32'(str_reg)) == 32'(stored_year_reg))
    `CDAW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

FILE: bench/tb_calendar_date_add_weekday.sv
// Self-checking testbench for the calendar date register with set, add and weekday.
module tb_calendar_date_add_weekday;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2500;
    localparam int RANDOM_ITEMS = 220;

    localparam int MONTH_CODE [13] = '{0, 0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    typedef struct packed {
        logic        ok;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [2:0]  wday;
    } date_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        kind        = cdaw_pkg::KIND_SET;
    logic [15:0] day_value   = '0;
    logic [15:0] month_value = '0;
    logic [15:0] year_value  = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        accepted;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic [2:0]  weekday;

    // Shadow copy of the stored date
    int unsigned cal_day   = cdaw_pkg::RESET_DAY;
    int unsigned cal_month = cdaw_pkg::RESET_MONTH;
    int unsigned cal_year  = cdaw_pkg::RESET_YEAR;

    date_result_t expected_dates[$];

    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;

    int errors       = 0;
    int results_seen = 0;
    int n_sets_ok    = 0;
    int n_refused    = 0;
    int n_adds       = 0;
    int cycle_count  = 0;

    calendar_date_add_weekday uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .day_value   (day_value),
        .month_value (month_value),
        .year_value  (year_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .cur_day     (cur_day),
        .cur_month   (cur_month),
        .cur_year    (cur_year),
        .weekday     (weekday)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- calendar math

    // Julian rule up to the split year, Gregorian after it
    function automatic bit leap_year(input int unsigned y);
        if (y > cdaw_pkg::YEAR_SPLIT)
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        return y % 4 == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        unique case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Push excess days into the following months, one month per pass
    function automatic void roll_days(inout int unsigned d, inout int unsigned m,
                                      inout int unsigned y);
        int unsigned len;
        forever
        begin
            len = days_in_month(m, y);
            if (len == 0 || d <= len)
                break;
            d = d - len;
            m = m + 1;
            if (m > 12)
            begin
                m = m - 12;
                y = (y + 1) & 32'hFFFF;
            end
        end
    endfunction

    function automatic logic [2:0] day_of_week(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned yy, ycode, mcode, ccode, lcode;
        yy    = y % 100;
        ycode = (yy + yy / 4) % 7;
        mcode = MONTH_CODE[(m <= 12) ? m : 0];
        lcode = (leap_year(y) && m <= 2) ? 1 : 0;
        if (y > cdaw_pkg::YEAR_SPLIT)
            ccode = cdaw_pkg::CENTURY_TAB[((y - cdaw_pkg::YEAR_SPLIT) / 100) & 3];
        else
            ccode = (cdaw_pkg::CENTURY_BASE - y / 100) % 7;
        return 3'((ycode + mcode + ccode + d + 7 - lcode) % 7);
    endfunction

    // Apply one transaction to the shadow date and return the expected result
    function automatic date_result_t predict_date(input logic k, input logic [15:0] dv,
                                                  input logic [15:0] mv,
                                                  input logic [15:0] yv);
        date_result_t r;
        int unsigned d, m, y, carry;
        r.ok = 1'b1;
        if (k == cdaw_pkg::KIND_SET)
        begin
            if (mv >= 1 && mv <= 12 && dv >= 1 && dv <= days_in_month(mv, yv))
            begin
                cal_day   = dv;
                cal_month = mv;
                cal_year  = yv;
            end
            else
            begin
                r.ok = 1'b0;
            end
        end
        else
        begin
            d = cal_day + dv;
            m = cal_month;
            y = cal_year;
            roll_days(d, m, y);
            m = m + mv;
            if (m > 12)
            begin
                carry = (m - 1) / 12;
                m     = (m - 1) % 12 + 1;
                y     = (y + carry) & 32'hFFFF;
            end
            y = (y + yv) & 32'hFFFF;
            roll_days(d, m, y);
            cal_day   = d;
            cal_month = m;
            cal_year  = y;
        end
        r.day   = 5'(cal_day);
        r.month = 4'(cal_month);
        r.year  = 16'(cal_year);
        r.wday  = day_of_week(cal_day, cal_month, cal_year);
        return r;
    endfunction

    // ---------------------------------------------------------------- driving

    // Called at a falling edge, returns at a falling edge with valid still high
    task automatic send_request(input logic k, input logic [15:0] dv, input logic [15:0] mv,
                                input logic [15:0] yv);
        date_result_t want;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        day_value   <= dv;
        month_value <= mv;
        year_value  <= yv;
        do @(posedge clk); while (!in_ready);
        want = predict_date(k, dv, mv, yv);
        expected_dates.push_back(want);
        if (k == cdaw_pkg::KIND_ADD)
            n_adds++;
        else if (want.ok)
            n_sets_ok++;
        else
            n_refused++;
        @(negedge clk);
    endtask

    always
    begin : result_sink
        @(negedge clk);
        if (hold_request)
        begin
            hold_request = 1'b0;
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_v,
                     act_v);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        date_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result transaction, actual %0d-%0d-%0d", $time,
                         cur_year, cur_month, cur_day);
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("accepted", 32'(want.ok), 32'(accepted));
                check_field("cur_day", 32'(want.day), 32'(cur_day));
                check_field("cur_month", 32'(want.month), 32'(cur_month));
                check_field("cur_year", 32'(want.year), 32'(cur_year));
                check_field("weekday", 32'(want.wday), 32'(weekday));
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("calendar_date_add_weekday test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // A zero add reports the reset date
    task automatic test_reset_date();
        send_request(cdaw_pkg::KIND_ADD, 16'd0, 16'd0, 16'd0);
    endtask

    task automatic test_set_extremes();
        send_request(cdaw_pkg::KIND_SET, 16'd31, 16'd12, 16'd65535);
        send_request(cdaw_pkg::KIND_SET, 16'd1, 16'd1, 16'd0);
        send_request(cdaw_pkg::KIND_SET, 16'd29, 16'd2, 16'd1700);  // Julian leap year
        send_request(cdaw_pkg::KIND_SET, 16'd29, 16'd2, 16'd2000);
        send_request(cdaw_pkg::KIND_SET, 16'd28, 16'd2, 16'd1900);
    endtask

    task automatic test_refused_sets();
        send_request(cdaw_pkg::KIND_SET, 16'd0, 16'd1, 16'd2000);
        send_request(cdaw_pkg::KIND_SET, 16'd32, 16'd1, 16'd2000);
        send_request(cdaw_pkg::KIND_SET, 16'd65535, 16'd65535, 16'd65535);
        send_request(cdaw_pkg::KIND_SET, 16'd1, 16'd0, 16'd2000);
        send_request(cdaw_pkg::KIND_SET, 16'd1, 16'd13, 16'd2000);
        send_request(cdaw_pkg::KIND_SET, 16'd29, 16'd2, 16'd1900);  // Gregorian century
        send_request(cdaw_pkg::KIND_SET, 16'd31, 16'd4, 16'd2024);
    endtask

    task automatic test_add_corners();
        send_request(cdaw_pkg::KIND_SET, 16'd31, 16'd1, 16'd2001);
        send_request(cdaw_pkg::KIND_ADD, 16'd0, 16'd1, 16'd0);    // Jan 31 + 1 month -> March
        send_request(cdaw_pkg::KIND_SET, 16'd29, 16'd2, 16'd2000);
        send_request(cdaw_pkg::KIND_ADD, 16'd0, 16'd0, 16'd1);    // Feb 29 + 1 year -> Mar 1
        send_request(cdaw_pkg::KIND_SET, 16'd31, 16'd12, 16'd65535);
        send_request(cdaw_pkg::KIND_ADD, 16'd1, 16'd0, 16'd0);    // year wraps to 0
        send_request(cdaw_pkg::KIND_ADD, 16'd0, 16'd0, 16'd65535);
        send_request(cdaw_pkg::KIND_ADD, 16'd0, 16'd65535, 16'd0);
        send_request(cdaw_pkg::KIND_ADD, 16'd65535, 16'd0, 16'd0);
        send_request(cdaw_pkg::KIND_SET, 16'd28, 16'd2, 16'd1700);
        send_request(cdaw_pkg::KIND_ADD, 16'd1, 16'd0, 16'd0);
    endtask

    // Sink holds off while the source keeps offering transactions
    task automatic test_output_stall();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++)
            send_request(cdaw_pkg::KIND_ADD, 16'($urandom_range(0, 40)),
                         16'($urandom_range(0, 3)), 16'd0);
    endtask

    task automatic test_random_mix(input int count);
        logic [15:0] dv, mv, yv;
        logic        k;
        int          sel;
        for (int i = 0; i < count; i++)
        begin
            if (i >= count - count / 5)
                idle_on = 1'b0;
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                k  = cdaw_pkg::KIND_SET;
                mv = 16'($urandom_range(1, 12));
                yv = $urandom_range(0, 1) ? 16'($urandom_range(1500, 2500))
                                          : 16'($urandom_range(0, 65535));
                dv = ($urandom_range(0, 3) == 0) ? 16'(days_in_month(mv, yv))
                                                 : 16'($urandom_range(1, days_in_month(mv, yv)));
            end
            else if (sel < 50)
            begin
                k  = cdaw_pkg::KIND_SET;
                dv = 16'($urandom_range(0, 65535));
                mv = 16'($urandom_range(0, 65535));
                yv = 16'($urandom_range(0, 65535));
            end
            else
            begin
                k  = cdaw_pkg::KIND_ADD;
                dv = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 400));
                mv = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 24));
                yv = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 5));
            end
            send_request(k, dv, mv, yv);
        end
    endtask

    initial
    begin : main
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_date();
        test_set_extremes();
        test_refused_sets();
        test_add_corners();
        test_output_stall();
        test_random_mix(RANDOM_ITEMS);

        in_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d set transactions (%0d refused) and %0d add transactions,",
                 n_sets_ok + n_refused, n_refused, n_adds);
        $display("including a long output stall; %0d results checked, %0d mismatches.",
                 results_seen, errors);
        if (errors == 0)
            $display("calendar_date_add_weekday test passed");
        else
            $display("calendar_date_add_weekday test failed");
        $finish;
    end

endmodule
